>>> rtl/max_stack_with_pop_max_macros.svh
// assertion macros used by the max stack rtl
`ifndef MAX_STACK_WITH_POP_MAX_MACROS_SVH
`define MAX_STACK_WITH_POP_MAX_MACROS_SVH

// same-cycle implication, off during reset
`define MSK_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define MSK_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/msk_pkg.sv
// types, constants and codes for the max stack
`timescale 1ns / 1ps

package msk_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int FUNC_W      = 2;
    localparam int STAT_W      = 2;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [CNT_W-1:0]              t_count;
    typedef logic [IDX_W-1:0]              t_index;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH    = 2'd0,
        FN_POP     = 2'd1,
        FN_POP_MAX = 2'd2,
        FN_QUERY   = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_WAVE = 2'd1,
        S_DONE = 2'd2
    } t_state;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic   push_en;
        logic   shift_en;
        t_value push_value;
        t_value max_value;
        t_count count;
    } t_bcast;

endpackage

>>> rtl/msk_if.sv
// valid/ready channel interfaces for the max stack operation and result
`timescale 1ns / 1ps

interface msk_in_if;
    import msk_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    t_value              push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface msk_out_if;
    import msk_pkg::*;

    logic                valid;
    logic                ready;
    t_value              removed_value;
    t_value              top_value;
    t_value              max_value;
    t_count              fill_count;
    logic [STAT_W-1:0]   status;

    modport source (output valid, output removed_value, output top_value,
                    output max_value, output fill_count, output status, input ready);
    modport sink   (input valid, input removed_value, input top_value,
                    input max_value, input fill_count, input status, output ready);
endinterface

>>> rtl/max_stack_with_pop_max.sv
// Bounded signed max stack built as a row of cells, one cell per entry, each holding
// its value and the running maximum of itself and everything below it. For push,
// pop, query and the flagged full or empty cases the transaction is applied to the
// cells in the accept cycle and the result register is loaded from S_DONE. Pop
// maximum shifts the cells above the removed entry down in the accept cycle; when
// those cells exist, a rebuild token then steps up the row one cell per cycle in
// S_WAVE to refresh the running maximum before S_DONE. A new transaction is
// accepted once the result register is loaded, also while that result still waits;
// the load itself waits on a stalled output.
`timescale 1ns / 1ps

`include "max_stack_with_pop_max_macros.svh"

module max_stack_with_pop_max (
    input  logic i_clk,
    input  logic i_rst_n,
    msk_in_if.sink    i_in,
    msk_out_if.source o_out
);
    import msk_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_count  r_count;
    t_value  r_removed;
    t_status r_status;

    logic    r_out_valid;
    t_value  r_out_removed;
    t_value  r_out_top;
    t_value  r_out_max;
    t_count  r_out_fill;
    t_status r_out_status;

    t_value  w_entry       [DEPTH];
    t_value  w_rmax        [DEPTH];
    t_value  w_top_e       [DEPTH];
    t_value  w_top_m       [DEPTH];
    t_value  w_prev_rmax   [DEPTH];
    t_value  w_next_entry  [DEPTH];
    logic    [DEPTH-1:0] w_match;
    logic    [DEPTH-1:0] w_match_above;
    logic    [DEPTH-1:0] w_token_in;
    logic    [DEPTH-1:0] w_token_out;
    logic    [DEPTH-1:0] w_token;

    t_value  w_top_entry;
    t_value  w_top_rmax;
    t_bcast  w_bcast;
    t_func   w_func;
    logic    w_fire;
    logic    w_full;
    logic    w_empty;
    logic    w_push_ok;
    logic    w_pop_ok;
    logic    w_popmax_ok;
    logic    w_need_wave;
    logic    w_capture;
    logic    w_in_ready;
    t_status w_status;
    t_value  w_removed;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_bottom
                assign w_prev_rmax[g] = '0;
                assign w_token_in[g]  = 1'b0;
            end else begin : g_mid
                assign w_prev_rmax[g] = w_rmax[g-1];
                assign w_token_in[g]  = w_token_out[g-1];
            end
            if (g == DEPTH - 1) begin : g_upper
                assign w_next_entry[g]  = '0;
                assign w_match_above[g] = 1'b0;
            end else begin : g_lower
                assign w_next_entry[g]  = w_entry[g+1];
                assign w_match_above[g] = w_match[g+1];
            end

            msk_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_idx        (t_index'(g)),
                .i_bcast      (w_bcast),
                .i_prev_rmax  (w_prev_rmax[g]),
                .i_next_entry (w_next_entry[g]),
                .i_match_above(w_match_above[g]),
                .i_token_in   (w_token_in[g]),
                .o_entry      (w_entry[g]),
                .o_rmax       (w_rmax[g]),
                .o_top_entry  (w_top_e[g]),
                .o_top_rmax   (w_top_m[g]),
                .o_match      (w_match[g]),
                .o_token_out  (w_token_out[g]),
                .o_token      (w_token[g])
            );
        end
    endgenerate

    // only the top cell drives a nonzero contribution
    always_comb begin
        w_top_entry = '0;
        w_top_rmax  = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_top_entry = w_top_entry | w_top_e[k];
            w_top_rmax  = w_top_rmax | w_top_m[k];
        end
    end

    assign w_func      = t_func'(i_in.func);
    assign w_fire      = i_in.valid && w_in_ready;
    assign w_full      = r_count == t_count'(DEPTH);
    assign w_empty     = r_count == '0;
    assign w_push_ok   = w_fire && (w_func == FN_PUSH) && !w_full;
    assign w_pop_ok    = w_fire && (w_func == FN_POP) && !w_empty;
    assign w_popmax_ok = w_fire && (w_func == FN_POP_MAX) && !w_empty;
    // the maximum sits below the top, so cells above it must shift and rebuild
    assign w_need_wave = w_popmax_ok && (w_top_entry != w_top_rmax);

    assign w_bcast.push_en    = w_push_ok;
    assign w_bcast.shift_en   = w_popmax_ok;
    assign w_bcast.push_value = i_in.push_value;
    assign w_bcast.max_value  = w_top_rmax;
    assign w_bcast.count      = r_count;

    always_comb begin
        w_status  = ST_OK;
        w_removed = '0;
        case (w_func)
            FN_PUSH: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end
            end
            FN_POP: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_removed = w_top_entry;
                end
            end
            FN_POP_MAX: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_removed = w_top_rmax;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    n_state = w_need_wave ? S_WAVE : S_DONE;
                end
            end
            S_WAVE: begin
                if (!(|w_token_out)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_capture  = 1'b0;
        case (r_state)
            S_IDLE:  w_in_ready = 1'b1;
            S_DONE:  w_capture  = !r_out_valid || o_out.ready;
            default: begin
                w_in_ready = 1'b0;
                w_capture  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_push_ok) begin
                r_count <= r_count + t_count'(1);
            end else if (w_pop_ok || w_popmax_ok) begin
                r_count <= r_count - t_count'(1);
            end
            if (w_capture) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_removed <= w_removed;
            r_status  <= w_status;
        end
        if (w_capture) begin
            r_out_removed <= r_removed;
            r_out_top     <= w_top_entry;
            r_out_max     <= w_top_rmax;
            r_out_fill    <= r_count;
            r_out_status  <= r_status;
        end
    end

    assign i_in.ready          = w_in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.removed_value = r_out_removed;
    assign o_out.top_value     = r_out_top;
    assign o_out.max_value     = r_out_max;
    assign o_out.fill_count    = r_out_fill;
    assign o_out.status        = r_out_status;

    `MSK_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= t_count'(DEPTH), "fill count above depth")
    `MSK_ASSERT_NOW(a_token_single, i_clk, i_rst_n, 1'b1, $onehot0(w_token), "more than one rebuild token")
    `MSK_ASSERT_NOW(a_token_in_wave, i_clk, i_rst_n, |w_token, r_state == S_WAVE, "rebuild token outside wave")
    `MSK_ASSERT_NEXT(a_wave_count, i_clk, i_rst_n, r_state == S_WAVE, $stable(r_count), "count moved during rebuild")

endmodule

>>> rtl/msk_cell.sv
// one stack cell: entry, running maximum and rebuild token
`timescale 1ns / 1ps

module msk_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  msk_pkg::t_index i_idx,
    input  msk_pkg::t_bcast i_bcast,
    input  msk_pkg::t_value i_prev_rmax,
    input  msk_pkg::t_value i_next_entry,
    input  logic            i_match_above,
    input  logic            i_token_in,
    output msk_pkg::t_value o_entry,
    output msk_pkg::t_value o_rmax,
    output msk_pkg::t_value o_top_entry,
    output msk_pkg::t_value o_top_rmax,
    output logic            o_match,
    output logic            o_token_out,
    output logic            o_token
);
    import msk_pkg::*;

    t_value r_entry;
    t_value r_rmax;
    logic   r_token;
    logic   n_token;

    t_count w_idx;
    logic   w_valid;
    logic   w_above_valid;
    logic   w_is_top;
    logic   w_match;
    logic   w_pos;
    logic   w_shift;
    logic   w_start;
    logic   w_push;
    t_value w_cand;
    t_value w_new_max;

    assign w_idx         = t_count'(i_idx);
    assign w_valid       = w_idx < i_bcast.count;
    assign w_above_valid = (w_idx + t_count'(1)) < i_bcast.count;
    assign w_is_top      = w_valid && !w_above_valid;
    assign w_match       = w_valid && (r_entry == i_bcast.max_value);
    // topmost match is the removal position
    assign w_pos         = w_match && !i_match_above;
    // cells from the removal position up to below the top take their upper neighbor
    assign w_shift       = i_bcast.shift_en && !i_match_above && w_above_valid;
    assign w_start       = i_bcast.shift_en && w_pos && w_above_valid;
    assign w_push        = i_bcast.push_en && (w_idx == i_bcast.count);

    assign w_cand        = w_push ? i_bcast.push_value : r_entry;
    assign w_new_max     = ((i_idx == '0) || (w_cand > i_prev_rmax)) ? w_cand : i_prev_rmax;

    assign n_token       = w_start | i_token_in;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry <= i_bcast.push_value;
            r_rmax  <= w_new_max;
        end else if (w_shift) begin
            r_entry <= i_next_entry;
        end else if (r_token) begin
            r_rmax  <= w_new_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= 1'b0;
        end else begin
            r_token <= n_token;
        end
    end

    assign o_entry     = r_entry;
    assign o_rmax      = r_rmax;
    assign o_top_entry = w_is_top ? r_entry : '0;
    assign o_top_rmax  = w_is_top ? r_rmax : '0;
    assign o_match     = i_match_above | w_match;
    // token moves up while the stack still has entries above
    assign o_token_out = r_token && w_above_valid;
    assign o_token     = r_token;

endmodule
